@@ rtl/lpzb_pkg.sv @@
// Shared types, constants and CORDIC helpers for the lidar point zone binning block.
package lpzb_pkg;

    typedef logic signed [26:0] t_cval;
    typedef logic signed [24:0] t_ang;

    typedef struct packed {
        t_cval x;
        t_cval y;
        t_ang  ang;
    } t_cordic;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         inten;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [15:0] rad;
        logic        exact;
        logic        found;
        logic [1:0]  zone;
    } t_mid;

    localparam logic [22:0] QUARTER_TURN = 23'd5898240;
    localparam logic [24:0] HALF_TURN    = 25'd11796480;
    localparam logic [24:0] FULL_TURN    = 25'd23592960;

    localparam logic [1:0] CLS_NOISE  = 2'd0;
    localparam logic [1:0] CLS_RANGE  = 2'd1;
    localparam logic [1:0] CLS_BINNED = 2'd2;
    localparam logic [1:0] CLS_NOZONE = 2'd3;

    localparam logic [2:0] REG_HLIM   = 3'd0;
    localparam logic [2:0] REG_ALIM   = 3'd1;
    localparam logic [2:0] REG_ILIM   = 3'd2;
    localparam logic [2:0] REG_MINR   = 3'd3;
    localparam logic [2:0] REG_MAXR   = 3'd4;
    localparam logic [2:0] REG_STARTS = 3'd5;
    localparam logic [2:0] REG_WIDTHS = 3'd6;
    localparam logic [2:0] REG_COUNTS = 3'd7;

    // full turn = 2^19 * 45; divide by 45 as multiply by reciprocal
    localparam int          SECT_SHIFT  = 19;
    localparam logic [14:0] DIV45_MUL   = 15'd23302;
    localparam int          DIV45_SHIFT = 20;

    function automatic t_ang atan_q16(input logic [3:0] idx);
        t_ang v;
        case (idx)
            4'd0:    v = 25'sd2949120;
            4'd1:    v = 25'sd1740967;
            4'd2:    v = 25'sd919879;
            4'd3:    v = 25'sd466945;
            4'd4:    v = 25'sd234379;
            4'd5:    v = 25'sd117304;
            4'd6:    v = 25'sd58666;
            4'd7:    v = 25'sd29335;
            4'd8:    v = 25'sd14668;
            4'd9:    v = 25'sd7334;
            4'd10:   v = 25'sd3667;
            4'd11:   v = 25'sd1833;
            4'd12:   v = 25'sd917;
            4'd13:   v = 25'sd458;
            4'd14:   v = 25'sd229;
            default: v = 25'sd115;
        endcase
        return v;
    endfunction

    function automatic t_cordic cordic_iter(input t_cordic c, input logic [3:0] idx);
        t_cordic n;
        t_cval   xs;
        t_cval   ys;
        xs = c.x >>> idx;
        ys = c.y >>> idx;
        if (!c.y[26]) begin
            n.x   = c.x + ys;
            n.y   = c.y - xs;
            n.ang = c.ang + atan_q16(idx);
        end else begin
            n.x   = c.x - ys;
            n.y   = c.y + xs;
            n.ang = c.ang - atan_q16(idx);
        end
        return n;
    endfunction

endpackage

@@ rtl/lpzb_isqrt.sv @@
// Pipelined integer square root, two result bits per stage.
module lpzb_isqrt (
    input  logic        i_clk,
    input  logic [31:0] i_val,
    output logic [15:0] o_root,
    output logic        o_exact
);
    localparam int STAGES = 8;

    logic [31:0] r_v   [STAGES];
    logic [31:0] r_res [STAGES];
    logic [31:0] s_v   [STAGES];
    logic [31:0] s_res [STAGES];

    for (genvar gs = 0; gs < STAGES; gs++) begin : g_st
        logic [31:0] n_v;
        logic [31:0] n_res;

        if (gs == 0) begin : g_first
            assign s_v[gs]   = i_val;
            assign s_res[gs] = '0;
        end else begin : g_next
            assign s_v[gs]   = r_v[gs-1];
            assign s_res[gs] = r_res[gs-1];
        end

        always_comb begin
            logic [31:0] v;
            logic [31:0] res;
            logic [31:0] b;
            logic [32:0] t;
            v   = s_v[gs];
            res = s_res[gs];
            for (int j = 0; j < 2; j++) begin
                b = 32'd1 << (5'(30 - 2 * (2 * gs + j)));
                t = {1'b0, res} + {1'b0, b};
                if ({1'b0, v} >= t) begin
                    v   = v - t[31:0];
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
            end
            n_v   = v;
            n_res = res;
        end

        always_ff @(posedge i_clk) begin
            r_v[gs]   <= n_v;
            r_res[gs] <= n_res;
        end
    end

    // zero remainder: the input is a perfect square
    assign o_root  = r_res[STAGES-1][15:0];
    assign o_exact = (r_v[STAGES-1] == '0);

endmodule

@@ rtl/lpzb_cordic.sv @@
// Pipelined 16-step vectoring CORDIC, first quadrant angle in Q16 degrees.
module lpzb_cordic (
    input  logic          i_clk,
    input  logic [15:0]   i_adj,
    input  logic [15:0]   i_opp,
    output lpzb_pkg::t_ang o_ang
);
    import lpzb_pkg::*;

    localparam int STAGES = 8;

    t_cordic r_c [STAGES];
    t_cordic s_c [STAGES];

    for (genvar gs = 0; gs < STAGES; gs++) begin : g_st
        t_cordic n_c;

        if (gs == 0) begin : g_first
            assign s_c[gs] = '{x: t_cval'({3'b0, i_adj, 8'b0}),
                               y: t_cval'({3'b0, i_opp, 8'b0}),
                               ang: '0};
        end else begin : g_next
            assign s_c[gs] = r_c[gs-1];
        end

        always_comb begin
            n_c = cordic_iter(cordic_iter(s_c[gs], 4'(2 * gs)), 4'(2 * gs + 1));
        end

        always_ff @(posedge i_clk) begin
            r_c[gs] <= n_c;
        end
    end

    assign o_ang = r_c[STAGES-1].ang;

endmodule

@@ rtl/lpzb_divider.sv @@
// Pipelined 16-bit restoring divider, two quotient bits per stage.
module lpzb_divider (
    input  logic        i_clk,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic [15:0] o_quot
);
    localparam int STAGES = 8;

    logic [15:0] r_rem [STAGES];
    logic [15:0] r_nq  [STAGES];
    logic [15:0] r_den [STAGES];
    logic [15:0] s_rem [STAGES];
    logic [15:0] s_nq  [STAGES];
    logic [15:0] s_den [STAGES];

    for (genvar gs = 0; gs < STAGES; gs++) begin : g_st
        logic [15:0] n_rem;
        logic [15:0] n_nq;

        if (gs == 0) begin : g_first
            assign s_rem[gs] = '0;
            assign s_nq[gs]  = i_num;
            assign s_den[gs] = i_den;
        end else begin : g_next
            assign s_rem[gs] = r_rem[gs-1];
            assign s_nq[gs]  = r_nq[gs-1];
            assign s_den[gs] = r_den[gs-1];
        end

        always_comb begin
            logic [15:0] rem;
            logic [15:0] nq;
            logic [16:0] t;
            logic        ge;
            rem = s_rem[gs];
            nq  = s_nq[gs];
            for (int j = 0; j < 2; j++) begin
                t   = {rem, nq[15]};
                ge  = t >= {1'b0, s_den[gs]};
                rem = ge ? 16'(t - {1'b0, s_den[gs]}) : t[15:0];
                nq  = {nq[14:0], ge};
            end
            n_rem = rem;
            n_nq  = nq;
        end

        always_ff @(posedge i_clk) begin
            r_rem[gs] <= n_rem;
            r_nq[gs]  <= n_nq;
            r_den[gs] <= s_den[gs];
        end
    end

    assign o_quot = r_nq[STAGES-1];

endmodule

@@ rtl/lidar_point_zone_binning.sv @@
// Top level: lidar point radius, noise and range classing, zone/ring/sector binning.
//
// A request (pos_x, pos_y, pos_z, intensity) is taken at a rising edge with start high
// and busy low. busy is always low: one request can be taken every cycle.
// Each request gives exactly one result, shown for one cycle with o_valid high;
// results come out in request order.
// The pipeline runs through the square root (8 stages), then the two angle CORDICs and the
// ring divider (8 stages each, in parallel), then the sector scaling multiplies.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it
// only while no request is in flight, as the block itself does not enforce this.
// Synchronous active-low reset clears the pipeline valid bits and loads the
// register reset values (maximum range all ones, everything else zero).
// The receiver cannot stall; results are not held.
module lidar_point_zone_binning #(
    parameter int NUM_ZONES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [7:0]         i_intensity,
    output logic               o_valid,
    output logic [1:0]         o_point_class,
    output logic [1:0]         o_zone_index,
    output logic [7:0]         o_ring_index,
    output logic [7:0]         o_sector_index,
    output logic [15:0]        o_radius
);
    import lpzb_pkg::*;

    localparam int DEPTH = 23;
    localparam int UNIT  = 8;

    // configuration
    logic signed [15:0] r_hlim;
    logic signed [15:0] r_alim;
    logic [7:0]         r_ilim;
    logic [15:0]        r_minr;
    logic [15:0]        r_maxr;
    logic [63:0]        r_starts;
    logic [63:0]        r_widths;
    logic [63:0]        r_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hlim   <= '0;
            r_alim   <= '0;
            r_ilim   <= '0;
            r_minr   <= '0;
            r_maxr   <= 16'hFFFF;
            r_starts <= '0;
            r_widths <= '0;
            r_counts <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HLIM:   r_hlim   <= i_cfg_data[15:0];
                REG_ALIM:   r_alim   <= i_cfg_data[15:0];
                REG_ILIM:   r_ilim   <= i_cfg_data[7:0];
                REG_MINR:   r_minr   <= i_cfg_data[15:0];
                REG_MAXR:   r_maxr   <= i_cfg_data[15:0];
                REG_STARTS: r_starts <= i_cfg_data;
                REG_WIDTHS: r_widths <= i_cfg_data;
                REG_COUNTS: r_counts <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // valid line
    logic             w_accept;
    logic [DEPTH-1:0] r_vld;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], w_accept};
        end
    end

    // stages 1..3: capture, squares, sum
    t_side       r1_side;
    t_side       r2_side;
    t_side       r3_side;
    logic [30:0] r2_sqx;
    logic [30:0] r2_sqy;
    logic [31:0] r3_r2;

    always_ff @(posedge i_clk) begin
        r1_side <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z, inten: i_intensity};
        r2_sqx  <= 31'(r1_side.x * r1_side.x);
        r2_sqy  <= 31'(r1_side.y * r1_side.y);
        r2_side <= r1_side;
        r3_r2   <= {1'b0, r2_sqx} + {1'b0, r2_sqy};
        r3_side <= r2_side;
    end

    // square root
    logic [15:0] w_rad;
    logic        w_exact;
    t_side       r_sdl1 [UNIT];

    lpzb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_val   (r3_r2),
        .o_root  (w_rad),
        .o_exact (w_exact)
    );

    always_ff @(posedge i_clk) begin
        r_sdl1[0] <= r3_side;
        for (int i = 1; i < UNIT; i++) begin
            r_sdl1[i] <= r_sdl1[i-1];
        end
    end

    // stage 12: zone select
    logic        w_found;
    logic [1:0]  w_zone;
    logic [15:0] w_start;
    logic [15:0] w_width;
    logic [79:0] w_ends;

    assign w_ends = {r_maxr, r_starts};

    always_comb begin
        logic [15:0] z_start;
        logic [15:0] z_width;
        logic [15:0] z_end;
        w_found = 1'b0;
        w_zone  = '0;
        w_start = '0;
        w_width = '0;
        for (int i = 0; i < NUM_ZONES; i++) begin
            z_start = r_starts[16*i +: 16];
            z_width = r_widths[16*i +: 16];
            z_end   = (i + 1 < NUM_ZONES) ? w_ends[16*(i+1) +: 16] : r_maxr;
            if (!w_found && z_width != '0 && w_rad >= z_start && w_rad < z_end) begin
                w_found = 1'b1;
                w_zone  = 2'(i);
                w_start = z_start;
                w_width = z_width;
            end
        end
    end

    t_mid        r12_mid;
    logic [15:0] r12_num;
    logic [15:0] r12_den;
    logic [15:0] r12_ax;
    logic [15:0] r12_ay;
    logic [15:0] r12_az;

    always_ff @(posedge i_clk) begin
        r12_mid <= '{side: r_sdl1[UNIT-1], rad: w_rad, exact: w_exact, found: w_found,
                     zone: w_zone};
        r12_num <= w_rad - w_start;
        r12_den <= w_width;
        r12_ax  <= r_sdl1[UNIT-1].x[15] ? 16'(-r_sdl1[UNIT-1].x) : 16'(r_sdl1[UNIT-1].x);
        r12_ay  <= r_sdl1[UNIT-1].y[15] ? 16'(-r_sdl1[UNIT-1].y) : 16'(r_sdl1[UNIT-1].y);
        r12_az  <= r_sdl1[UNIT-1].z[15] ? 16'(-r_sdl1[UNIT-1].z) : 16'(r_sdl1[UNIT-1].z);
    end

    // angle and ring units
    t_ang        w_inc_ang;
    t_ang        w_yaw_ang;
    logic [15:0] w_quot;
    t_mid        r_sdl2 [UNIT];

    lpzb_cordic u_inc_cordic (
        .i_clk (i_clk),
        .i_adj (r12_mid.rad),
        .i_opp (r12_az),
        .o_ang (w_inc_ang)
    );

    lpzb_cordic u_yaw_cordic (
        .i_clk (i_clk),
        .i_adj (r12_ax),
        .i_opp (r12_ay),
        .o_ang (w_yaw_ang)
    );

    lpzb_divider u_ring_div (
        .i_clk  (i_clk),
        .i_num  (r12_num),
        .i_den  (r12_den),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        r_sdl2[0] <= r12_mid;
        for (int i = 1; i < UNIT; i++) begin
            r_sdl2[i] <= r_sdl2[i-1];
        end
    end

    // stage 21: classing, ring clip, yaw and sector product
    t_mid        w_m;
    logic [1:0]  n21_cls;
    logic [7:0]  n21_ring;
    logic [7:0]  n21_smax;
    logic [32:0] n21_prod;

    assign w_m = r_sdl2[UNIT-1];

    always_comb begin
        logic [22:0]        h;
        logic [23:0]        hr;
        logic [15:0]        imag;
        logic signed [16:0] inc;
        logic signed [16:0] alim;
        logic [22:0]        a;
        logic [24:0]        yaw;
        logic [7:0]         rings;
        logic [7:0]         sects;
        logic [7:0]         rmax;
        logic [7:0]         seff;
        logic               noise;
        logic               out_rng;

        if (w_m.side.z == '0) begin
            h = '0;
        end else if (w_m.rad == '0) begin
            h = QUARTER_TURN;
        end else if (w_inc_ang[24]) begin
            h = '0;
        end else if (w_inc_ang[23:0] > {1'b0, QUARTER_TURN}) begin
            h = QUARTER_TURN;
        end else begin
            h = w_inc_ang[22:0];
        end
        hr   = {1'b0, h} + 24'd128;
        imag = hr[23:8];
        inc  = w_m.side.z[15] ? -$signed({1'b0, imag}) : $signed({1'b0, imag});
        alim = {r_alim[15], r_alim};

        // radius equal to the upper bound is only in range for a perfect square
        noise   = (w_m.side.z < r_hlim) && (inc < alim) && (w_m.side.inten < r_ilim);
        out_rng = (w_m.rad < r_minr) || (w_m.rad > r_maxr) ||
                  (w_m.rad == r_maxr && !w_m.exact);

        if (noise) begin
            n21_cls = CLS_NOISE;
        end else if (out_rng) begin
            n21_cls = CLS_RANGE;
        end else if (w_m.found) begin
            n21_cls = CLS_BINNED;
        end else begin
            n21_cls = CLS_NOZONE;
        end

        if (w_m.side.y == '0) begin
            a = '0;
        end else if (w_m.side.x == '0) begin
            a = QUARTER_TURN;
        end else if (w_yaw_ang[24]) begin
            a = '0;
        end else if (w_yaw_ang[23:0] > {1'b0, QUARTER_TURN}) begin
            a = QUARTER_TURN;
        end else begin
            a = w_yaw_ang[22:0];
        end

        case ({w_m.side.x[15], w_m.side.y[15]})
            2'b00:   yaw = {2'b0, a};
            2'b10:   yaw = HALF_TURN - {2'b0, a};
            2'b11:   yaw = HALF_TURN + {2'b0, a};
            default: yaw = FULL_TURN - {2'b0, a};
        endcase
        if (yaw >= FULL_TURN) begin
            yaw = FULL_TURN - 25'd1;
        end

        rings = r_counts[{w_m.zone, 4'b0000} +: 8];
        sects = r_counts[{w_m.zone, 4'b1000} +: 8];
        rmax  = (rings == '0) ? 8'd0 : rings - 8'd1;
        seff  = (sects == '0) ? 8'd1 : sects;

        n21_ring = (w_quot > {8'b0, rmax}) ? rmax : w_quot[7:0];
        n21_smax = seff - 8'd1;
        n21_prod = 33'(yaw) * 33'(seff);
    end

    logic [1:0]  r21_cls;
    logic [1:0]  r21_zone;
    logic [7:0]  r21_ring;
    logic [7:0]  r21_smax;
    logic [15:0] r21_rad;
    logic [32:0] r21_prod;

    always_ff @(posedge i_clk) begin
        r21_cls  <= n21_cls;
        r21_zone <= w_m.zone;
        r21_ring <= n21_ring;
        r21_smax <= n21_smax;
        r21_rad  <= w_m.rad;
        r21_prod <= n21_prod;
    end

    // stage 22: divide by 45 via reciprocal
    logic [1:0]  r22_cls;
    logic [1:0]  r22_zone;
    logic [7:0]  r22_ring;
    logic [7:0]  r22_smax;
    logic [15:0] r22_rad;
    logic [28:0] r22_pmul;

    always_ff @(posedge i_clk) begin
        r22_cls  <= r21_cls;
        r22_zone <= r21_zone;
        r22_ring <= r21_ring;
        r22_smax <= r21_smax;
        r22_rad  <= r21_rad;
        r22_pmul <= 29'(r21_prod[32:SECT_SHIFT]) * 29'(DIV45_MUL);
    end

    // stage 23: sector clip and output registers
    logic [8:0] w_sect;
    logic       w_binned;
    logic [1:0] r_out_cls;
    logic [1:0] r_out_zone;
    logic [7:0] r_out_ring;
    logic [7:0] r_out_sect;
    logic [15:0] r_out_rad;

    assign w_sect   = r22_pmul[28:DIV45_SHIFT];
    assign w_binned = (r22_cls == CLS_BINNED);

    always_ff @(posedge i_clk) begin
        r_out_cls  <= r22_cls;
        r_out_rad  <= r22_rad;
        r_out_zone <= w_binned ? r22_zone : 2'd0;
        r_out_ring <= w_binned ? r22_ring : 8'd0;
        if (!w_binned) begin
            r_out_sect <= '0;
        end else if (w_sect > {1'b0, r22_smax}) begin
            r_out_sect <= r22_smax;
        end else begin
            r_out_sect <= w_sect[7:0];
        end
    end

    assign o_valid        = r_vld[DEPTH-1];
    assign o_point_class  = r_out_cls;
    assign o_zone_index   = r_out_zone;
    assign o_ring_index   = r_out_ring;
    assign o_sector_index = r_out_sect;
    assign o_radius       = r_out_rad;

endmodule

@@ rtl/lpzb_checker.sv @@
// Port-level assertions for the lidar point zone binning block, with bind.
module lpzb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_point_class,
    input logic [1:0]  o_zone_index,
    input logic [7:0]  o_ring_index,
    input logic [7:0]  o_sector_index,
    input logic [15:0] o_radius
);
    import lpzb_pkg::*;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##23 o_valid)
        else $error("result missing 23 cycles after request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 23))
        else $error("result without matching request");

    a_unbinned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point_class != CLS_BINNED) |->
            (o_zone_index == 2'd0 && o_ring_index == 8'd0 && o_sector_index == 8'd0))
        else $error("unbinned result carries bin indexes");

    a_radius_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_radius <= 16'd46341))
        else $error("radius beyond reachable maximum");

endmodule

bind lidar_point_zone_binning lpzb_checker u_lpzb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_point_class  (o_point_class),
    .o_zone_index   (o_zone_index),
    .o_ring_index   (o_ring_index),
    .o_sector_index (o_sector_index),
    .o_radius       (o_radius)
);
